### rtl/sdr_pkg.sv
// shared constants and types for the stream duplicate remover
// no dependencies

package sdr_pkg;

   localparam int unsigned VALUE_W       = 32;
   localparam int unsigned DEPTH_DEFAULT = 64;

   typedef struct packed {
      logic hit;
      logic full;
   } sdr_lookup_type;

   typedef struct packed {
      logic valid;
      logic last;
   } sdr_update_type;

endpackage : sdr_pkg

### rtl/stream_duplicate_remover.sv
// stream duplicate remover top level: input register, table lookup, result register
// depends on sdr_pkg and sdr_cam
//
// usage:
//   req channel (req_valid/req_ready) carries one signed 32-bit value per
//   transaction and req_last on the final element of a set.
//   rsp channel (rsp_valid/rsp_ready) returns one transaction per input:
//   the value, keep (first occurrence in the set), overflow (new value not
//   recorded because the table of DEPTH entries is full) and last_out.
//   an accepted transaction passes the input register, then the result
//   register, whose valid is rsp_valid.
//   throughput: 1 transaction per cycle unless rsp stalls; the lookup is a
//   combinational parallel compare of the input register with all DEPTH entries.
//   the table is cleared after the set's last element is judged.
//   reset: synchronous, clears both pipeline valids and the table count.
//   a stalled receiver holds the result register; the input register still
//   takes one more transaction, then req_ready drops until rsp drains.

module stream_duplicate_remover
   import sdr_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_value_out,
   output logic                      rsp_keep,
   output logic                      rsp_overflow,
   output logic                      rsp_last_out
);

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic                      in_valid_ff;
   logic                      in_valid_in;
   logic signed [VALUE_W-1:0] in_value_ff;
   logic                      in_last_ff;
   logic                      out_valid_ff;
   logic                      out_valid_in;
   logic signed [VALUE_W-1:0] out_value_ff;
   logic                      out_keep_ff;
   logic                      out_overflow_ff;
   logic                      out_last_ff;
   logic                      advance;
   sdr_lookup_type            lookup;
   sdr_update_type            update;
   logic [CNT_W-1:0]          count;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign update.valid = advance;
   assign update.last  = in_last_ff;

   sdr_cam #(
      .DEPTH(DEPTH)
   ) u_cam (
      .clock       (clock),
      .reset       (reset),
      .lookup_value(in_value_ff),
      .update      (update),
      .lookup      (lookup),
      .count       (count)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_value_ff <= req_value;
         in_last_ff  <= req_last;
      end
      if (advance) begin
         out_value_ff    <= in_value_ff;
         out_keep_ff     <= !lookup.hit;
         out_overflow_ff <= !lookup.hit && lookup.full;
         out_last_ff     <= in_last_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_value_out = out_value_ff;
   assign rsp_keep      = out_keep_ff;
   assign rsp_overflow  = out_overflow_ff;
   assign rsp_last_out  = out_last_ff;

`ifndef NO_ASSERTIONS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count <= CNT_W'(DEPTH))
      else $error("table count exceeds depth");

   a_overflow_keep : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_keep)
      else $error("overflow on a dropped duplicate");

   a_clear_after_last : assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> count == '0)
      else $error("table not cleared after end of set");

   a_grow_on_new : assert property (@(posedge clock) disable iff (reset)
      advance && !in_last_ff && !lookup.hit && !lookup.full
      |=> count == $past(count) + CNT_W'(1))
      else $error("new value not recorded");
`endif

endmodule : stream_duplicate_remover

### rtl/sdr_cam.sv
// table of distinct values seen in the current set, compared in parallel
// depends on sdr_pkg

module sdr_cam
   import sdr_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEFAULT,
   localparam int unsigned CNT_W = $clog2(DEPTH + 1),
   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic signed [VALUE_W-1:0]   lookup_value,
   input  sdr_update_type              update,
   output sdr_lookup_type              lookup,
   output logic [CNT_W-1:0]            count
);

   logic [VALUE_W-1:0] entries_ff [DEPTH];
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [DEPTH-1:0]   match;
   logic               full;
   logic               record;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
      assign match[i] = (CNT_W'(i) < count_ff) &&
                        (entries_ff[i] == VALUE_W'(lookup_value));
   end

   assign full        = (count_ff == CNT_W'(DEPTH));
   assign lookup.hit  = |match;
   assign lookup.full = full;
   assign count       = count_ff;
   assign record      = update.valid && !lookup.hit && !full;

   always_comb begin
      count_in = count_ff;
      if (record) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (update.valid && update.last) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (record) begin
         entries_ff[count_ff[IDX_W-1:0]] <= VALUE_W'(lookup_value);
      end
   end

endmodule : sdr_cam

### verif/sdr_checker.sv
// transaction checker for the stream duplicate remover: tracks the per-set table of seen values
// and compares every rsp transaction with the oldest predicted one
// depends on sdr_pkg

module sdr_checker
   import sdr_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [VALUE_W-1:0] rsp_value_out,
   input  logic                      rsp_keep,
   input  logic                      rsp_overflow,
   input  logic                      rsp_last_out,
   output int                        mismatches,
   output int                        outstanding
);

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      keep;
      logic                      overflow;
      logic                      last;
   } dedup_result_type;

   dedup_result_type     dedup_expected_q[$];
   logic [VALUE_W-1:0]   seen_tbl [DEPTH];
   int unsigned          seen_cnt;

   always @(posedge clock) begin : monitor
      dedup_result_type want;
      dedup_result_type judged;
      logic             hit;
      if (reset) begin
         dedup_expected_q.delete();
         seen_cnt   = 0;
         mismatches = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (dedup_expected_q.size() == 0) begin
               $error("unexpected transaction: value_out %0d", rsp_value_out);
               mismatches++;
            end else begin
               want = dedup_expected_q.pop_front();
               if (rsp_value_out !== want.value) begin
                  $error("value_out: expected %0d, got %0d", want.value, rsp_value_out);
                  mismatches++;
               end
               if (rsp_keep !== want.keep) begin
                  $error("keep: expected %0b, got %0b", want.keep, rsp_keep);
                  mismatches++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $error("overflow: expected %0b, got %0b", want.overflow, rsp_overflow);
                  mismatches++;
               end
               if (rsp_last_out !== want.last) begin
                  $error("last_out: expected %0b, got %0b", want.last, rsp_last_out);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            hit = 1'b0;
            for (int i = 0; i < seen_cnt; i++) begin
               if (seen_tbl[i] == req_value) hit = 1'b1;
            end
            judged.value    = req_value;
            judged.last     = req_last;
            judged.keep     = !hit;
            judged.overflow = 1'b0;
            if (!hit) begin
               if (seen_cnt < DEPTH) begin
                  seen_tbl[seen_cnt] = req_value;
                  seen_cnt++;
               end else begin
                  judged.overflow = 1'b1;
               end
            end
            dedup_expected_q.push_back(judged);
            // end of set clears the table after the element is judged
            if (req_last) seen_cnt = 0;
         end
      end
      outstanding = dedup_expected_q.size();
   end

endmodule : sdr_checker

### verif/testbench.sv
// top of the stream duplicate remover test: clock, reset, req stimulus and rsp back-pressure
// depends on sdr_pkg, stream_duplicate_remover and sdr_checker

module testbench;
   import sdr_pkg::*;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      req_last = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0] rsp_value_out;
   logic                      rsp_keep;
   logic                      rsp_overflow;
   logic                      rsp_last_out;
   int                        mismatches;
   int                        outstanding;
   int                        send_idle_pct = 0;
   int                        recv_stall_pct = 0;

   always #5 clock = ~clock;

   stream_duplicate_remover dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_out (rsp_value_out),
      .rsp_keep      (rsp_keep),
      .rsp_overflow  (rsp_overflow),
      .rsp_last_out  (rsp_last_out)
   );

   sdr_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_out (rsp_value_out),
      .rsp_keep      (rsp_keep),
      .rsp_overflow  (rsp_overflow),
      .rsp_last_out  (rsp_last_out),
      .mismatches    (mismatches),
      .outstanding   (outstanding)
   );

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(1, 100) > recv_stall_pct);
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic l);
      if ($urandom_range(1, 100) <= send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_last  <= l;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] v;
      v = $urandom;
      if ($urandom_range(0, 15) == 0) begin
         case ($urandom_range(0, 3))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7fff_ffff;
            2:       v = 32'h0000_0000;
            default: v = 32'hffff_ffff;
         endcase
      end
      return v;
   endfunction

   task automatic run_phase(input int n_items);
      int                 sent;
      int                 kind;
      int                 len;
      int                 k;
      logic [VALUE_W-1:0] pool [80];
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            // short set drawn from a few values
            len = $urandom_range(1, 12);
            k   = $urandom_range(1, 8);
            for (int i = 0; i < k; i++) pool[i] = pick_value();
            for (int i = 0; i < len; i++) send_item(pool[$urandom_range(0, k - 1)], i == len - 1);
            sent += len;
         end else if (kind < 85) begin
            // long set of 60 to 72 values that can fill the table, then repeats recorded and unrecorded values
            k = $urandom_range(60, 72);
            for (int i = 0; i < 80; i++) pool[i] = pick_value();
            for (int i = 0; i < k; i++) send_item(pool[i], 1'b0);
            len = $urandom_range(10, 40);
            for (int i = 0; i < len; i++) send_item(pool[$urandom_range(0, 71)], i == len - 1);
            sent += k + len;
         end else begin
            // noise with random set boundaries
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) send_item($urandom, $urandom_range(0, 3) == 0);
            sent += len;
         end
      end
   endtask

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, duplicates, last on new and on duplicate values
      send_item(32'sh0000_0000, 1'b0);
      send_item(-32'sd1, 1'b0);
      send_item(32'sh7fff_ffff, 1'b0);
      send_item(32'sh8000_0000, 1'b0);
      send_item(32'sh0000_0000, 1'b0);
      send_item(32'sh8000_0000, 1'b0);
      send_item(32'sh7fff_ffff, 1'b0);
      send_item(32'sh0000_0001, 1'b1);
      send_item(32'sh0000_0000, 1'b0);
      send_item(32'sh0000_0000, 1'b1);
      send_item(32'sh7fff_ffff, 1'b1);
      send_item(32'sh7fff_ffff, 1'b1);
      send_item(-32'sd1, 1'b0);
      send_item(32'sh0000_0001, 1'b0);
      send_item(-32'sd1, 1'b0);
      send_item(32'sh8000_0000, 1'b1);
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 71;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 71;
            end
            default: begin
               send_idle_pct  = 25;
               recv_stall_pct = 25;
            end
         endcase
         run_phase(375);
         drain_results();
      end

      recv_stall_pct = 0;
      repeat (10) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule : testbench

### sim.f
rtl/sdr_pkg.sv
rtl/sdr_cam.sv
rtl/stream_duplicate_remover.sv
verif/sdr_checker.sv
verif/testbench.sv
